[sv/lctb_pkg.sv]
// ---------------------------------------------------------------------------
// lctb_pkg: shared types and constants of the line-capped text buffer
// Command codes, status codes, request and result structs.
// ---------------------------------------------------------------------------
package lctb_pkg;

    localparam int unsigned STORE_DEPTH_DEF = 4096;
    localparam int unsigned MAX_LINES_DEF   = 256;
    localparam int unsigned TAB_STOP_DEF    = 8;

    localparam int CHAR_W = 21;
    localparam int LNUM_W = 9;
    localparam int COL_W  = 16;

    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_GET     = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BELL     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [CHAR_W-1:0] CH_BELL    = 21'd7;
    localparam logic [CHAR_W-1:0] CH_TAB     = 21'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 21'd10;

    typedef struct packed {
        logic [1:0]        command;
        logic [CHAR_W-1:0] character;
        logic [LNUM_W-1:0] line_number;
        logic [COL_W-1:0]  column;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] found_char;
        logic [1:0]        status;
        logic [LNUM_W-1:0] lines_held;
    } rsp_t;

endpackage

[sv/line_capped_text_buffer.sv]
// Every command ends in S_OUT, which raises the result. A push with a newline may first
// evict the oldest line; a get first sums line lengths up to line_number, then walks
// that line's characters until the column is reached or the line ends.
// Throughput: one request at a time; the next is taken once the result has gone, and the
// two-entry intake queue lets requests wait while a get walks.
// Reset: synchronous, active low; clears counters and line valid bits, line_cap 0.
// ---------------------------------------------------------------------------
// line_capped_text_buffer: terminal scrollback store
// Front queue feeding a sequencer over character and line-length memories.
// ---------------------------------------------------------------------------
module line_capped_text_buffer #(
    parameter int unsigned STORE_DEPTH = lctb_pkg::STORE_DEPTH_DEF,
    parameter int unsigned MAX_LINES   = lctb_pkg::MAX_LINES_DEF,
    parameter int unsigned TAB_STOP    = lctb_pkg::TAB_STOP_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lctb_pkg::LNUM_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lctb_pkg::req_t              s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lctb_pkg::rsp_t              m_data
);
    import lctb_pkg::*;

    logic              q_valid, q_ready;
    req_t              q_data;
    logic [LNUM_W-1:0] line_cap_reg;

    // hold the line cap; writes always taken
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_cap_reg <= '0;
        end else if (cfg_valid) begin
            line_cap_reg <= cfg_data;
        end
    end

    lctb_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    lctb_engine #(
        .STORE_DEPTH(STORE_DEPTH), .MAX_LINES(MAX_LINES), .TAB_STOP(TAB_STOP)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn), .line_cap(line_cap_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

[sv/lctb_front.sv]
// ---------------------------------------------------------------------------
// lctb_front: request intake
// Accept requests into a two-entry queue that decouples the engine.
// ---------------------------------------------------------------------------
module lctb_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lctb_pkg::req_t  s_data,
    output logic            q_valid,
    input  logic            q_ready,
    output lctb_pkg::req_t  q_data
);
    import lctb_pkg::*;

    req_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= s_data;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !s_ready) else $error("queue overflow");
    a_cnt_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("bad queue count");
    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 2'd1) else $error("pop lost");
`endif
endmodule

[sv/lctb_engine.sv]
// ---------------------------------------------------------------------------
// lctb_engine: command sequencer
// Carry out push, get and clear against the character and line memories.
// ---------------------------------------------------------------------------
module lctb_engine #(
    parameter int unsigned STORE_DEPTH = lctb_pkg::STORE_DEPTH_DEF,
    parameter int unsigned MAX_LINES   = lctb_pkg::MAX_LINES_DEF,
    parameter int unsigned TAB_STOP    = lctb_pkg::TAB_STOP_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lctb_pkg::LNUM_W-1:0] line_cap,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  lctb_pkg::req_t              q_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lctb_pkg::rsp_t              m_data
);
    import lctb_pkg::*;

    localparam int CA_W = $clog2(STORE_DEPTH);
    localparam int CC_W = CA_W + 1;
    localparam int LA_W = $clog2(MAX_LINES);
    localparam int LC_W = LA_W + 1;
    localparam int TS_W = $clog2(TAB_STOP);
    localparam int CL_W = (CC_W > COL_W + 1) ? CC_W : COL_W + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CLR   = 11'b00000000010,
        S_PLEN  = 11'b00000000100,
        S_PUPD  = 11'b00000001000,
        S_EVRD  = 11'b00000010000,
        S_EVUP  = 11'b00000100000,
        S_GSUM  = 11'b00001000000,
        S_GLEN  = 11'b00010000000,
        S_GRD   = 11'b00100000000,
        S_GCHK  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [CHAR_W-1:0] cmem [STORE_DEPTH];
    logic [CC_W-1:0]   lmem [MAX_LINES];
    logic [MAX_LINES-1:0] lvalid_reg;

    logic [CHAR_W-1:0] crd_reg;
    logic [CC_W-1:0]   lrd_raw_reg;
    logic              lrd_v_reg;
    logic [CC_W-1:0]   lrd;

    logic [CA_W-1:0] char_head_reg;
    logic [CC_W-1:0] char_count_reg;
    logic [LA_W-1:0] line_head_reg;
    logic [LC_W-1:0] line_count_reg;

    req_t            req_reg;
    logic [LC_W-1:0] k_reg;
    logic [CC_W-1:0] off_reg, size_reg, j_reg;
    logic [CL_W-1:0] i_reg;
    logic [TS_W-1:0] tpos_reg;
    logic [LA_W-1:0] clr_reg;
    rsp_t            out_reg;
    logic            out_v_reg;

    // line memory access control
    logic            lwe, lre;
    logic [LA_W-1:0] lwa, lra;
    logic [CC_W-1:0] lwd;

    logic [LA_W-1:0] last_slot;
    logic [LC_W-1:0] gline;
    logic [CC_W-1:0] new_count, evlen;
    logic            evict;
    logic [CL_W-1:0] extra, col_w;

    assign lrd       = lrd_v_reg ? lrd_raw_reg : '0;
    assign last_slot = line_head_reg + LA_W'(line_count_reg - LC_W'(1));
    assign gline     = LC_W'(req_reg.line_number);
    assign new_count = char_count_reg + CC_W'(1);
    assign evict     = ((line_cap != '0) && (32'(line_count_reg) > 32'(line_cap)))
                       || (line_count_reg >= LC_W'(MAX_LINES));
    assign evlen     = (lrd > char_count_reg) ? char_count_reg : lrd;
    // tpos_reg tracks (column - 1) modulo the tab stop
    assign extra     = CL_W'(TAB_STOP - 1) - CL_W'(tpos_reg);
    assign col_w     = CL_W'(req_reg.column);

    assign q_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    always_comb begin
        lwe = 1'b0; lwa = '0; lwd = '0; lre = 1'b0; lra = '0;
        case (state_reg)
            S_IDLE: begin
                lre = 1'b1;
                lra = (q_data.command == CMD_GET) ? line_head_reg : last_slot;
            end
            S_PUPD: begin
                lwe = 1'b1; lwa = last_slot; lwd = lrd + CC_W'(1);
                lre = 1'b1; lra = line_head_reg;
            end
            S_EVUP: begin
                lwe = 1'b1; lwa = line_head_reg; lwd = '0;
            end
            S_GSUM: begin
                lre = 1'b1; lra = line_head_reg + LA_W'(k_reg + LC_W'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (lwe) lmem[lwa] <= lwd;
        if (lre) lrd_raw_reg <= lmem[lra];
        if (state_reg == S_PLEN && req_reg.character != CH_BELL
            && char_count_reg < CC_W'(STORE_DEPTH))
            cmem[char_head_reg + CA_W'(char_count_reg)] <= req_reg.character;
        crd_reg <= cmem[char_head_reg + CA_W'(off_reg + j_reg)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            lvalid_reg     <= '0;
            lrd_v_reg      <= 1'b0;
            char_head_reg  <= '0;
            char_count_reg <= '0;
            line_head_reg  <= '0;
            line_count_reg <= LC_W'(1);
            out_v_reg      <= 1'b0;
        end else begin
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            if (lre) lrd_v_reg <= lvalid_reg[lra];
            if (lwe) lvalid_reg[lwa] <= 1'b1;
            case (state_reg)
                S_CLR: begin
                    // line table reset uses valid bits, so lmem itself is not cleared
                    lvalid_reg     <= '0;
                    char_head_reg  <= '0;
                    char_count_reg <= '0;
                    line_head_reg  <= '0;
                    line_count_reg <= LC_W'(1);
                    state_reg      <= (req_reg.command == CMD_CLEAR && clr_reg != '0)
                                      ? S_OUT : S_IDLE;
                    out_reg        <= '{found_char: '0, status: ST_DONE, lines_held: 9'd1};
                end
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        req_reg  <= q_data;
                        k_reg    <= '0;
                        off_reg  <= '0;
                        j_reg    <= '0;
                        i_reg    <= CL_W'(1);
                        tpos_reg <= '0;
                        out_reg  <= '{found_char: '0, status: ST_DONE,
                                      lines_held: LNUM_W'(line_count_reg)};
                        case (q_data.command)
                            CMD_PUSH:  state_reg <= S_PLEN;
                            CMD_GET:   state_reg <= S_GSUM;
                            CMD_CLEAR: begin
                                clr_reg   <= LA_W'(1);
                                state_reg <= S_CLR;
                            end
                            default:   state_reg <= S_OUT;
                        endcase
                    end
                end
                S_PLEN: begin
                    if (req_reg.character == CH_BELL) begin
                        out_reg.status <= ST_BELL;
                        state_reg      <= S_OUT;
                    end else if (char_count_reg >= CC_W'(STORE_DEPTH)) begin
                        out_reg.status <= ST_FULL;
                        state_reg      <= S_OUT;
                    end else begin
                        char_count_reg <= new_count;
                        state_reg      <= S_PUPD;
                    end
                end
                S_PUPD: begin
                    if (req_reg.character == CH_NEWLINE) begin
                        state_reg <= S_EVRD;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_EVRD: begin
                    // lrd holds the oldest line's length as read before this push's update
                    if (evict) begin
                        state_reg <= S_EVUP;
                    end else begin
                        lvalid_reg[line_head_reg + LA_W'(line_count_reg)] <= 1'b0;
                        line_count_reg     <= line_count_reg + LC_W'(1);
                        out_reg.lines_held <= LNUM_W'(line_count_reg + LC_W'(1));
                        state_reg          <= S_OUT;
                    end
                end
                S_EVUP: begin
                    // drop the oldest line; net line count unchanged
                    char_head_reg  <= char_head_reg + CA_W'(evlen);
                    char_count_reg <= char_count_reg - evlen;
                    line_head_reg  <= line_head_reg + LA_W'(1);
                    lvalid_reg[line_head_reg + LA_W'(line_count_reg)] <= 1'b0;
                    out_reg.lines_held <= LNUM_W'(line_count_reg);
                    state_reg      <= S_OUT;
                end
                S_GSUM: begin
                    if (gline == '0 || req_reg.column == '0 || gline > line_count_reg) begin
                        out_reg.status <= ST_NOTFOUND;
                        state_reg      <= S_OUT;
                    end else if (k_reg + LC_W'(1) < gline) begin
                        off_reg <= off_reg + lrd;
                        k_reg   <= k_reg + LC_W'(1);
                    end else begin
                        size_reg  <= lrd;
                        state_reg <= S_GLEN;
                    end
                end
                S_GLEN: begin
                    if (j_reg >= size_reg) begin
                        out_reg.status <= ST_NOTFOUND;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_GRD;
                    end
                end
                S_GRD: state_reg <= S_GCHK;
                S_GCHK: begin
                    if (col_w == i_reg || (crd_reg == CH_TAB && col_w > i_reg
                                           && col_w <= i_reg + extra)) begin
                        out_reg.found_char <= crd_reg;
                        state_reg          <= S_OUT;
                    end else begin
                        i_reg     <= i_reg + CL_W'(1)
                                     + ((crd_reg == CH_TAB) ? extra : '0);
                        tpos_reg  <= (crd_reg == CH_TAB
                                      || tpos_reg == TS_W'(TAB_STOP - 1))
                                     ? '0 : tpos_reg + TS_W'(1);
                        j_reg     <= j_reg + CC_W'(1);
                        state_reg <= S_GLEN;
                    end
                end
                S_OUT: begin
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        char_count_reg <= CC_W'(STORE_DEPTH)) else $error("char count over depth");
    a_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        line_count_reg != '0 && line_count_reg <= LC_W'(MAX_LINES))
        else $error("line count out of range");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_oh: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
`endif
endmodule
